/* rtl/b2da_pkg.sv */
// Package for the binary to decimal ASCII unit.
// Holds the digit constants and the converter status type; depends on nothing.
package b2da_pkg;

  localparam int DefValueBits = 16;
  localparam int NumDigits    = 5;
  localparam int DigitW       = 4;
  localparam int BcdW         = NumDigits * DigitW;
  localparam int CharW        = 6;
  localparam int RemW         = $clog2(NumDigits + 1);

  localparam logic [CharW-1:0]  AsciiZero = CharW'(48);
  localparam logic [DigitW-1:0] DigitFive = DigitW'(5);
  localparam logic [DigitW-1:0] DigitAdj  = DigitW'(3);

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

endpackage

/* rtl/b2da_dabble.sv */
// Bit-serial binary to BCD converter using the shift and add-three method.
// Depends on b2da_pkg for the digit constants and the status type.
module b2da_dabble #(
  parameter int VALUE_BITS = b2da_pkg::DefValueBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [VALUE_BITS-1:0]      value_i,
  output b2da_pkg::conv_status_t     status_o,
  output logic [b2da_pkg::BcdW-1:0]  bcd_o
);
  import b2da_pkg::*;

  localparam int CntW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, adj;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitFive) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitAdj;
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CntW'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        bcd_d = {adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
        bin_d = bin_q << 1;
        cnt_d = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (cnt_q == '0);
  assign bcd_o         = bcd_q;

endmodule

/* rtl/b2da_emit.sv */
// Digit serializer: shifts BCD digits out most significant first, drops
// leading zeros and drives the registered character output. Uses b2da_pkg.
module b2da_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [b2da_pkg::BcdW-1:0]  bcd_i,
  output logic                       active_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [b2da_pkg::CharW-1:0] char_code_o,
  output logic                       is_last_o
);
  import b2da_pkg::*;

  logic [BcdW-1:0]   dig_q, dig_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic              active_q, active_d;
  logic              seen_q, seen_d;
  logic              valid_q, valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic [DigitW-1:0] top;
  logic              final_dig, show, slot_free;

  assign top       = dig_q[BcdW-1 -: DigitW];
  assign final_dig = (rem_q == RemW'(1));
  assign show      = seen_q || (top != '0) || final_dig;
  assign slot_free = !valid_q || out_ready_i;

  always_comb begin
    dig_d    = dig_q;
    rem_d    = rem_q;
    active_d = active_q;
    seen_d   = seen_q;
    valid_d  = valid_q;
    char_d   = char_q;
    last_d   = last_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      dig_d    = bcd_i;
      rem_d    = RemW'(NumDigits);
      active_d = 1'b1;
      seen_d   = 1'b0;
    end else if (active_q && slot_free) begin
      dig_d  = dig_q << DigitW;
      rem_d  = rem_q - 1'b1;
      seen_d = seen_q || show;
      if (final_dig) begin
        active_d = 1'b0;
      end
      if (show) begin
        valid_d = 1'b1;
        char_d  = AsciiZero + CharW'(top);
        last_d  = final_dig;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      rem_q    <= '0;
      seen_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign active_o    = active_q;
  assign out_valid_o = valid_q;
  assign char_code_o = char_q;
  assign is_last_o   = last_q;

endmodule

/* rtl/binary_to_decimal_ascii_unit.sv */
// Top level of the binary to decimal ASCII unit.
// Instantiates b2da_dabble and b2da_emit; uses b2da_pkg.
//
// The input channel takes one unsigned value per request. The output
// channel returns one ASCII digit per request, most significant first,
// with leading zeros dropped, and is_last marks the least significant
// digit. The value zero gives a single '0'.
// The conversion shifts one input bit per cycle through a five digit
// BCD register. The serializer then steps through every digit of that
// register in turn, skipped leading zeros included. A new value is
// taken once the last digit has moved into the output register, even
// while that digit still waits there for the receiver.
// Reset clears all control state and leaves the output channel empty.
// When the receiver stalls the output register holds its character and
// the serializer waits; the next value is not taken before the last
// digit has moved into the output register.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = b2da_pkg::DefValueBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [VALUE_BITS-1:0]      value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [b2da_pkg::CharW-1:0] char_code_o,
  output logic                       is_last_o
);
  import b2da_pkg::*;

  conv_status_t    conv_status;
  logic [BcdW-1:0] bcd;
  logic            emit_active;
  logic            start;

  assign in_ready_o = !conv_status.busy && !emit_active;
  assign start      = in_valid_i && in_ready_o;

  b2da_dabble #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .status_o(conv_status),
    .bcd_o   (bcd)
  );

  b2da_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (conv_status.done),
    .bcd_i      (bcd),
    .active_o   (emit_active),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .is_last_o  (is_last_o)
  );

endmodule

/* rtl/b2da_checker.sv */
// Port level checks for the binary to decimal ASCII unit, with the bind
// that attaches them to the top level. Uses b2da_pkg for the code limits.
module b2da_checker #(
  parameter int VALUE_BITS = b2da_pkg::DefValueBits
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [VALUE_BITS-1:0]      value_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [b2da_pkg::CharW-1:0] char_code_o,
  input logic                       is_last_o
);
  import b2da_pkg::*;

  // A waiting request keeps its value until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(value_i))
    else $error("waiting request changed");

  // An accepted request occupies the converter, so ready must drop.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after a request");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o >= AsciiZero) && (char_code_o <= AsciiZero + CharW'(9)))
    else $error("character code outside the digit range");

  // Once a digit has been sent, the rest of the run follows without gaps.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !is_last_o |=> out_valid_o)
    else $error("gap inside a digit run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o) && $stable(is_last_o))
    else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_b2da_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .char_code_o(char_code_o),
  .is_last_o  (is_last_o)
);

/* dv/tb_top.sv */
// Testbench for binary_to_decimal_ascii_unit: fixed and random 16-bit values, checked ASCII out.
// Predicts the digit characters of each request itself; depends on b2da_pkg and the RTL top.
module tb_top;
  import b2da_pkg::*;

  localparam int ValueBits  = DefValueBits;
  localparam int Radix      = 10;
  localparam int MaxGap     = 18;
  localparam int DrainWait  = ValueBits + 12;
  localparam int LongHold   = 200;
  localparam int WdogLimit  = 2000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } digit_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ValueBits-1:0] value;
  logic                 out_valid;
  logic                 out_ready;
  logic [CharW-1:0]     char_code;
  logic                 is_last;

  digit_char_t digit_chars_q[$];
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          hold_req;
  int          values_sent;
  int          chars_checked;
  int          err_cnt;
  int          quiet_cycles;

  binary_to_decimal_ascii_unit #(
    .VALUE_BITS(ValueBits)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .char_code_o(char_code),
    .is_last_o  (is_last)
  );

  always #4 clk = ~clk;

  // Splits the value into five decimal digits and queues every digit from the first
  // nonzero one onward; zero leaves only the units digit.
  task automatic queue_decimal_digits(input logic [ValueBits-1:0] val);
    int unsigned rem;
    logic [3:0]  dig [NumDigits];
    int          first;
    digit_char_t item;
    rem = val;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      dig[i] = 4'(rem % Radix);
      rem = rem / Radix;
    end
    first = NumDigits - 1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      if (dig[i] != 4'd0) begin
        first = i;
      end
    end
    for (int i = first; i < NumDigits; i++) begin
      item.code = AsciiZero + CharW'(dig[i]);
      item.last = (i == NumDigits - 1);
      digit_chars_q.push_back(item);
    end
  endtask

  function automatic logic [ValueBits-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: rand_value = ValueBits'($urandom_range(0, 9));
      1: rand_value = ValueBits'($urandom_range(10, 99));
      2: rand_value = ValueBits'($urandom_range(100, 999));
      3: rand_value = ValueBits'($urandom_range(1000, 9999));
      4: rand_value = ValueBits'($urandom_range(10000, 65535));
      default: rand_value = ValueBits'($urandom);
    endcase
  endfunction

  task automatic send_value(input logic [ValueBits-1:0] val);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    queue_decimal_digits(val);
    values_sent++;
  endtask

  task automatic wait_all_chars();
    in_valid <= 1'b0;
    while (digit_chars_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [ValueBits-1:0] vals [$];
    vals = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
             16'd9999, 16'd10000, 16'd65535, 16'h8000, 16'h5555, 16'hAAAA,
             16'd12345, 16'd60000, 16'd10001, 16'd40960, 16'd100, 16'd0};
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    foreach (vals[i]) send_value(vals[i]);
    wait_all_chars();
  endtask

  task automatic test_random_mix(input int count);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (count) send_value(rand_value());
    wait_all_chars();
  endtask

  task automatic test_back_to_back(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_value(rand_value());
    wait_all_chars();
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_output_stall(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_req   = LongHold;
    repeat (count) send_value(rand_value());
    wait_all_chars();
  endtask

  task automatic test_mixed_idling(input int count);
    repeat (count) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 10)) send_value(rand_value());
    end
    wait_all_chars();
  endtask

  initial begin
    int rx_wait;
    int hold_cnt;
    rx_wait  = 0;
    hold_cnt = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        rx_wait = rx_idle_en ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digit_char_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (digit_chars_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports) begin
          $display("ERROR: unexpected char %0d is_last %0d", char_code, is_last);
        end
      end else begin
        exp_item = digit_chars_q.pop_front();
        if (char_code !== exp_item.code || is_last !== exp_item.last) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("ERROR: expected char %0d is_last %0d, got char %0d is_last %0d",
                     exp_item.code, exp_item.last, char_code, is_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WdogLimit) begin
      $display("ERROR: no request moved for %0d cycles", WdogLimit);
      $display("binary_to_decimal_ascii_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    value         = '0;
    out_ready     = 1'b0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    hold_req      = 0;
    values_sent   = 0;
    chars_checked = 0;
    err_cnt       = 0;
    quiet_cycles  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(200);
    test_back_to_back(120);
    test_output_stall(40);
    test_mixed_idling(18);

    $display("Sent %0d values and checked %0d digit characters, covering zero, every digit",
             values_sent, chars_checked);
    $display("count, full scale, back-to-back requests and a long output stall.");
    if (err_cnt == 0 && digit_chars_q.size() == 0) begin
      $display("binary_to_decimal_ascii_unit: match");
    end else begin
      $display("binary_to_decimal_ascii_unit: mismatch");
    end
    $finish;
  end

endmodule
